### rtl/core/sgcs_pkg.sv
// ----------------------------------------------------------------------------
// sgcs_pkg
// Shared types and constants for the sphere gravity contact step.
// ----------------------------------------------------------------------------
package sgcs_pkg;

  localparam logic [30:0] GravityReset = 31'd642908;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Square-root pipeline: one result bit per stage, radicand below 2^64.
  localparam int SqrtBits = 32;

  typedef enum logic [1:0] {
    OUT_TOUCH   = 2'd0,
    OUT_FREE    = 2'd1,
    OUT_CONTACT = 2'd2
  } outcome_e;

  // Item handed from the classifier to the resolver.
  typedef struct packed {
    logic        touch;
    logic        hit;
    logic [31:0] mx;
    logic [31:0] mz;
    logic [31:0] nvy;
    logic [31:0] my_free;
    logic [32:0] u;        // -(sy - oy)
    logic [63:0] disc;     // R*R - h2, zero when negative
  } front_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) r = 32'h7fffffff;
    else if (x < -66'sd2147483648) r = 32'h80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

### rtl/core/sgcs_front.sv
// ----------------------------------------------------------------------------
// sgcs_front
// Pipelined classifier: touch test, free move, post-move test, discriminant.
// ----------------------------------------------------------------------------
module sgcs_front import sgcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        in_vld_i,
  input  logic [30:0] gravity_i,
  input  logic [31:0] self_x_i,
  input  logic [31:0] self_y_i,
  input  logic [31:0] self_z_i,
  input  logic [30:0] self_radius_i,
  input  logic [31:0] other_x_i,
  input  logic [31:0] other_y_i,
  input  logic [31:0] other_z_i,
  input  logic [30:0] other_radius_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [16:0] delta_time_i,
  output logic        out_vld_o,
  output front_t      out_o
);

  // stage 1: differences, radius sum, products with dt
  logic [3:0]          v1_q;
  logic signed [32:0]  dx1_q, dy1_q, dz1_q;
  logic [31:0]         rsum1_q;
  logic signed [49:0]  pvx1_q, pvz1_q;
  logic [47:0]         gdt1_q;
  logic signed [31:0]  vy1_q;
  logic [16:0]         dt1_q;
  // stage 2: squares, moves, gdt
  logic [65:0]         sq2_q, r22_q;
  logic [31:0]         mx2_q, mz2_q, nvy2_q;
  logic [31:0]         gdt2;
  logic [48:0]         half2_q;
  logic signed [32:0]  dx2_q, dy2_q, dz2_q;
  logic [16:0]         dt2_q;
  // stage 3
  logic                touch3_q;
  logic [65:0]         r23_q;
  logic [31:0]         mx3_q, mz3_q, nvy3_q, my3_q;
  logic signed [32:0]  dy3_q;
  logic signed [49:0]  nvdt3;
  // stage 4: post-move squares, up to three terms near 2^66 each
  logic                touch4_q;
  logic [65:0]         r24_q;
  logic [67:0]         h24_q, s4y_q;
  logic [31:0]         mx4_q, mz4_q, nvy4_q, my4_q;
  logic signed [32:0]  u4_q;
  logic signed [33:0]  ex3, ez3;

  // valid follows the five register stages of the data path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= '0;
      out_vld_o <= 1'b0;
    end else if (adv_i) begin
      v1_q <= {v1_q[2:0], in_vld_i};
      out_vld_o <= v1_q[3];
    end
  end

  assign gdt2 = gdt1_q[47:16];

  always_comb begin
    nvdt3 = $signed(nvy2_q) * $signed({1'b0, dt2_q});
    ex3 = 34'(dx2_q) + 34'($signed(mx2_q));
    ez3 = 34'(dz2_q) + 34'($signed(mz2_q));
  end

  logic signed [65:0] my3_full;
  assign my3_full = 66'(nvdt3 >>> 16) - 66'($signed({1'b0, half2_q[48:17]}));

  logic signed [33:0] ex3_q, ez3_q, ey4;
  always_comb ey4 = 34'(dy3_q) + 34'($signed(my3_q));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx1_q   <= 33'($signed(self_x_i)) - 33'($signed(other_x_i));
      dy1_q   <= 33'($signed(self_y_i)) - 33'($signed(other_y_i));
      dz1_q   <= 33'($signed(self_z_i)) - 33'($signed(other_z_i));
      rsum1_q <= 32'(self_radius_i) + 32'(other_radius_i);
      pvx1_q  <= $signed(vel_x_i) * $signed({1'b0, delta_time_i});
      pvz1_q  <= $signed(vel_z_i) * $signed({1'b0, delta_time_i});
      gdt1_q  <= gravity_i * delta_time_i;
      vy1_q   <= $signed(vel_y_i);
      dt1_q   <= delta_time_i;

      sq2_q  <= 66'(dx1_q * dx1_q) + 66'(dy1_q * dy1_q) + 66'(dz1_q * dz1_q);
      r22_q  <= 66'(rsum1_q * rsum1_q);
      mx2_q  <= sat32(66'(pvx1_q >>> 16));
      mz2_q  <= sat32(66'(pvz1_q >>> 16));
      nvy2_q <= sat32(66'(vy1_q) - 66'($signed({1'b0, gdt2})));
      half2_q <= gdt2 * dt1_q;
      dx2_q <= dx1_q; dy2_q <= dy1_q; dz2_q <= dz1_q; dt2_q <= dt1_q;

      touch3_q <= sq2_q <= r22_q;
      r23_q <= r22_q;
      mx3_q <= mx2_q; mz3_q <= mz2_q; nvy3_q <= nvy2_q;
      my3_q <= sat32(my3_full);
      dy3_q <= dy2_q;
      ex3_q <= ex3; ez3_q <= ez3;

      touch4_q <= touch3_q;
      r24_q <= r23_q;
      h24_q <= 68'(ex3_q * ex3_q) + 68'(ez3_q * ez3_q);
      s4y_q <= 68'(ey4 * ey4);
      mx4_q <= mx3_q; mz4_q <= mz3_q; nvy4_q <= nvy3_q; my4_q <= my3_q;
      u4_q <= -dy3_q;

      out_o.touch   <= touch4_q;
      out_o.hit     <= (h24_q + s4y_q) <= {2'b00, r24_q};
      out_o.mx      <= mx4_q;
      out_o.mz      <= mz4_q;
      out_o.nvy     <= nvy4_q;
      out_o.my_free <= my4_q;
      out_o.u       <= u4_q;
      out_o.disc    <= ({2'b00, r24_q} > h24_q) ? r24_q[63:0] - h24_q[63:0] : 64'd0;
    end
  end

endmodule

### rtl/core/sgcs_queue.sv
// ----------------------------------------------------------------------------
// sgcs_queue
// Short queue between classifier and resolver.
// ----------------------------------------------------------------------------
module sgcs_queue import sgcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  front_t data_i,
  input  logic   pop_i,
  output logic   empty_o,
  output logic   full_o,
  output front_t data_o
);

  front_t mem_q [QDepth];
  logic [QAw-1:0] wp_q, rp_q;
  logic [QAw:0]   cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (QAw+1)'(QDepth);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(push_i) - (QAw+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> !empty_o) else $error("push lost");

endmodule

### rtl/core/sgcs_back.sv
// ----------------------------------------------------------------------------
// sgcs_back
// Resolver: pipelined square root and root choice, one item per cycle while adv_i is high.
// ----------------------------------------------------------------------------
module sgcs_back import sgcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        in_vld_i,
  input  front_t      in_i,
  output logic        out_vld_o,
  output logic [31:0] move_x_o,
  output logic [31:0] move_y_o,
  output logic [31:0] move_z_o,
  output logic [31:0] new_vel_y_o,
  output logic [1:0]  outcome_o
);

  localparam int N = SqrtBits;

  logic   vld_q [N+1];
  front_t it_q  [N+1];
  logic [63:0] rem_q [N+1];
  logic [31:0] root_q [N+1];

  assign vld_q[0]  = in_vld_i;
  assign it_q[0]   = in_i;
  assign rem_q[0]  = in_i.disc;
  assign root_q[0] = '0;

  // restoring square root, one result bit per stage from the top
  for (genvar k = 0; k < N; k++) begin : g_sq
    localparam int B = N - 1 - k;
    logic [65:0] trial;
    always_comb trial = 66'({root_q[k], 2'b01}) << (2 * B);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (adv_i) vld_q[k+1] <= vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        it_q[k+1] <= it_q[k];
        if (66'(rem_q[k]) >= trial) begin
          rem_q[k+1]  <= rem_q[k] - trial[63:0];
          root_q[k+1] <= {root_q[k][30:0], 1'b1};
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= {root_q[k][30:0], 1'b0};
        end
      end
    end
  end

  front_t f;
  logic signed [34:0] ra, rb, ma, mb;
  logic [31:0] my;
  logic [1:0]  oc;
  always_comb begin
    f  = it_q[N];
    ra = 35'($signed(f.u)) + 35'({1'b0, root_q[N]});
    rb = 35'($signed(f.u)) - 35'({1'b0, root_q[N]});
    ma = ra < 0 ? -ra : ra;
    mb = rb < 0 ? -rb : rb;
    if (f.touch) begin
      my = '0; oc = OUT_TOUCH;
    end else if (f.hit) begin
      my = sat32(66'(ma < mb ? ra : rb)); oc = OUT_CONTACT;
    end else begin
      my = f.my_free; oc = OUT_FREE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_o <= 1'b0;
    else if (adv_i) out_vld_o <= vld_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      move_x_o    <= f.mx;
      move_z_o    <= f.mz;
      move_y_o    <= my;
      new_vel_y_o <= f.touch ? 32'd0 : f.nvy;
      outcome_o   <= oc;
    end
  end

endmodule

### rtl/core/sphere_gravity_contact_step.sv
// ----------------------------------------------------------------------------
// sphere_gravity_contact_step
// Sphere pair motion step with gravity and contact root, Q16.16.
//
//  channel   | handshake          | payload
//  input     | push / full        | self_*, other_*, vel_*, delta_time_i
//  result    | empty / pop        | move_*_o, new_vel_y_o, outcome_o
//  config    | gravity_we_i       | gravity_i
//
// One item per cycle sustained while results are popped; a result passes 5
// front stages, the queue memory, 33 back stages and 1 output register.
// The 32 one-bit square-root stages in the back part set the depth.
// Reset clears all valid state; gravity returns to 9.81.
// Front stalls when the queue is full and its last stage holds an item; back
// stalls when its last stage holds a result and the output one is not taken.
// ----------------------------------------------------------------------------
module sphere_gravity_contact_step import sgcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gravity_we_i,
  input  logic [30:0] gravity_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] self_x_i,
  input  logic [31:0] self_y_i,
  input  logic [31:0] self_z_i,
  input  logic [30:0] self_radius_i,
  input  logic [31:0] other_x_i,
  input  logic [31:0] other_y_i,
  input  logic [31:0] other_z_i,
  input  logic [30:0] other_radius_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [16:0] delta_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] move_x_o,
  output logic [31:0] move_y_o,
  output logic [31:0] move_z_o,
  output logic [31:0] new_vel_y_o,
  output logic [1:0]  outcome_o
);

  logic [30:0] gravity_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gravity_q <= GravityReset;
    else if (gravity_we_i) gravity_q <= gravity_i;
  end

  // front pipeline runs while its last stage can drain into the queue
  logic   f_vld, q_empty, q_full, q_pop, f_adv, b_adv, b_vld, o_pop;
  front_t f_data, q_data;
  logic   ob_v_q;
  logic [31:0] ob_x_q, ob_y_q, ob_z_q, ob_n_q;
  logic [1:0]  ob_o_q;
  logic [31:0] bx, by, bz, bn;
  logic [1:0]  bo;

  assign f_adv = !(f_vld && q_full);
  assign full  = !f_adv;

  sgcs_front u_front (
    .clk_i, .rst_ni, .adv_i(f_adv), .in_vld_i(push && f_adv), .gravity_i(gravity_q),
    .self_x_i, .self_y_i, .self_z_i, .self_radius_i,
    .other_x_i, .other_y_i, .other_z_i, .other_radius_i,
    .vel_x_i, .vel_y_i, .vel_z_i, .delta_time_i,
    .out_vld_o(f_vld), .out_o(f_data)
  );

  sgcs_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_vld && f_adv), .data_i(f_data), .pop_i(q_pop),
    .empty_o(q_empty), .full_o(q_full), .data_o(q_data)
  );

  // back pipeline advances when its last stage is empty or its output slot is free or being taken
  assign b_adv = !(b_vld && ob_v_q && !o_pop);
  assign q_pop = b_adv && !q_empty;
  assign o_pop = pop && ob_v_q;

  sgcs_back u_back (
    .clk_i, .rst_ni, .adv_i(b_adv), .in_vld_i(q_pop), .in_i(q_data),
    .out_vld_o(b_vld), .move_x_o(bx), .move_y_o(by), .move_z_o(bz),
    .new_vel_y_o(bn), .outcome_o(bo)
  );

  // output register: takes the back result when the slot frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ob_v_q <= 1'b0;
    else if (b_vld && b_adv) ob_v_q <= 1'b1;
    else if (o_pop) ob_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (b_vld && b_adv) begin
      ob_x_q <= bx; ob_y_q <= by; ob_z_q <= bz; ob_n_q <= bn; ob_o_q <= bo;
    end
  end

  assign empty = !ob_v_q;
  assign move_x_o = ob_x_q;
  assign move_y_o = ob_y_q;
  assign move_z_o = ob_z_q;
  assign new_vel_y_o = ob_n_q;
  assign outcome_o = ob_o_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_v_q && !pop |=> ob_v_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_v_q |-> outcome_o != 2'd3) else $error("bad outcome");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outcome_o == OUT_TOUCH && ob_v_q |-> move_y_o == '0 && new_vel_y_o == '0)
    else $error("touch result not zeroed");

endmodule

### tb/sgcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcs_checker
// Watches the input, result and gravity ports of the sphere contact step,
// predicts each result from its own model and compares field by field.
// ----------------------------------------------------------------------------
module sgcs_checker import sgcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gravity_we_i,
  input  logic [30:0] gravity_i,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] self_x_i,
  input  logic [31:0] self_y_i,
  input  logic [31:0] self_z_i,
  input  logic [30:0] self_radius_i,
  input  logic [31:0] other_x_i,
  input  logic [31:0] other_y_i,
  input  logic [31:0] other_z_i,
  input  logic [30:0] other_radius_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [16:0] delta_time_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] move_x_i,
  input  logic [31:0] move_y_i,
  input  logic [31:0] move_z_i,
  input  logic [31:0] new_vel_y_i,
  input  logic [1:0]  outcome_i,
  output int          err_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [31:0] nvy;
    outcome_e    outcome;
  } motion_t;

  logic [30:0] grav_q;
  motion_t     motion_q[$];

  function automatic logic [31:0] clamp32(longint signed x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic [127:0] sq(longint signed d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] op, res, b;
    op = v;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > op) b = b >> 2;
    while (b != 0) begin
      if (op >= res + b) begin
        op = op - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic motion_t step_motion(logic [30:0] g);
    longint signed sx, sy, sz, ox, oy, oz, vx, vy, vz, dt, mx, my, mz, nvy;
    longint signed gdt, half, u, ra, rb, s;
    logic [127:0]  r2, h2;
    motion_t       r;
    sx = longint'($signed(self_x_i));
    sy = longint'($signed(self_y_i));
    sz = longint'($signed(self_z_i));
    ox = longint'($signed(other_x_i));
    oy = longint'($signed(other_y_i));
    oz = longint'($signed(other_z_i));
    vx = longint'($signed(vel_x_i));
    vy = longint'($signed(vel_y_i));
    vz = longint'($signed(vel_z_i));
    dt = longint'(delta_time_i);
    r2 = sq(longint'(self_radius_i) + longint'(other_radius_i));
    mx = longint'($signed(clamp32((vx * dt) >>> 16)));
    mz = longint'($signed(clamp32((vz * dt) >>> 16)));
    if (sq(sx - ox) + sq(sy - oy) + sq(sz - oz) <= r2) begin
      my = 0;
      nvy = 0;
      r.outcome = OUT_TOUCH;
    end else begin
      gdt = (longint'(g) * dt) >> 16;
      half = (gdt * dt) >> 17;
      nvy = longint'($signed(clamp32(vy - gdt)));
      my = longint'($signed(clamp32(((nvy * dt) >>> 16) - half)));
      h2 = sq(sx + mx - ox) + sq(sz + mz - oz);
      if (h2 + sq(sy + my - oy) <= r2) begin
        s = 0;
        if (r2 > h2) s = longint'(root64(r2[63:0] - h2[63:0]));
        u = oy - sy;
        ra = u + s;
        rb = u - s;
        my = longint'($signed(clamp32(((ra < 0 ? -ra : ra) < (rb < 0 ? -rb : rb)) ? ra : rb)));
        r.outcome = OUT_CONTACT;
      end else begin
        r.outcome = OUT_FREE;
      end
    end
    r.mx = mx[31:0];
    r.my = my[31:0];
    r.mz = mz[31:0];
    r.nvy = nvy[31:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    motion_t e;
    int      taken;
    int      added;
    if (!rst_ni) begin
      grav_q <= GravityReset;
      err_cnt_o <= 0;
      pending_o <= 0;
      motion_q.delete();
    end else begin
      taken = 0;
      added = 0;
      if (gravity_we_i) grav_q <= gravity_i;
      if (pop && !empty) begin
        if (motion_q.size() == 0) begin
          if (err_cnt_o < 10) $display("unexpected result transfer at %0t", $realtime);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          e = motion_q.pop_front();
          taken = 1;
          if (move_x_i !== e.mx || move_y_i !== e.my || move_z_i !== e.mz ||
              new_vel_y_i !== e.nvy || outcome_i !== e.outcome) begin
            if (err_cnt_o < 10)
              $display("mismatch at %0t: exp mx %h my %h mz %h vy %h oc %0d, got %h %h %h %h %0d",
                       $realtime, e.mx, e.my, e.mz, e.nvy, e.outcome,
                       move_x_i, move_y_i, move_z_i, new_vel_y_i, outcome_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (push && !full) begin
        motion_q.push_back(step_motion(grav_q));
        added = 1;
      end
      pending_o <= pending_o + added - taken;
    end
  end

endmodule

### tb/tb_sphere_gravity_contact_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_gravity_contact_step
// Directed and random sphere pairs under several gravity settings, with
// random idle gaps on both sides; results are checked by sgcs_checker.
// ----------------------------------------------------------------------------
module tb_sphere_gravity_contact_step;
  import sgcs_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk, rst_n, grav_we, push, full, empty, pop;
  logic [30:0] grav, self_r, other_r;
  logic [31:0] self_x, self_y, self_z, other_x, other_y, other_z;
  logic [31:0] vel_x, vel_y, vel_z, move_x, move_y, move_z, new_vel_y;
  logic [16:0] dt;
  logic [1:0]  outcome;
  int          err_cnt, pending, idle_cycles;
  bit          push_steady, pop_steady;

  sphere_gravity_contact_step uut (
    .clk_i(clk), .rst_ni(rst_n), .gravity_we_i(grav_we), .gravity_i(grav),
    .push(push), .full(full),
    .self_x_i(self_x), .self_y_i(self_y), .self_z_i(self_z), .self_radius_i(self_r),
    .other_x_i(other_x), .other_y_i(other_y), .other_z_i(other_z),
    .other_radius_i(other_r), .vel_x_i(vel_x), .vel_y_i(vel_y), .vel_z_i(vel_z),
    .delta_time_i(dt), .empty(empty), .pop(pop),
    .move_x_o(move_x), .move_y_o(move_y), .move_z_o(move_z),
    .new_vel_y_o(new_vel_y), .outcome_o(outcome)
  );

  sgcs_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .gravity_we_i(grav_we), .gravity_i(grav),
    .push(push), .full(full),
    .self_x_i(self_x), .self_y_i(self_y), .self_z_i(self_z), .self_radius_i(self_r),
    .other_x_i(other_x), .other_y_i(other_y), .other_z_i(other_z),
    .other_radius_i(other_r), .vel_x_i(vel_x), .vel_y_i(vel_y), .vel_z_i(vel_z),
    .delta_time_i(dt), .empty(empty), .pop(pop),
    .move_x_i(move_x), .move_y_i(move_y), .move_z_i(move_z),
    .new_vel_y_i(new_vel_y), .outcome_i(outcome),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one pair and hold it until its transfer.
  task automatic send_pair(logic [31:0] sx, sy, sz, logic [30:0] rs,
                           logic [31:0] ox, oy, oz, logic [30:0] ro,
                           logic [31:0] vx, vy, vz, logic [16:0] t);
    int gap;
    gap = push_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    self_x <= sx; self_y <= sy; self_z <= sz; self_r <= rs;
    other_x <= ox; other_y <= oy; other_z <= oz; other_r <= ro;
    vel_x <= vx; vel_y <= vy; vel_z <= vz; dt <= t;
    push <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic random_pair();
    logic [31:0] ox, oy, oz;
    logic [30:0] rs, ro;
    int          mode;
    mode = $urandom_range(0, 9);
    ox = $signed($urandom_range(0, 4000000)) - 2000000;
    oy = $signed($urandom_range(0, 4000000)) - 2000000;
    oz = $signed($urandom_range(0, 4000000)) - 2000000;
    rs = $urandom_range(1000, 200000);
    ro = $urandom_range(1000, 200000);
    if (mode < 6) begin
      // falling onto the fixed sphere from just above
      send_pair(ox + $urandom_range(0, 60000) - 30000,
                oy + rs + ro + $urandom_range(1, 40000),
                oz + $urandom_range(0, 60000) - 30000, rs, ox, oy, oz, ro,
                $urandom_range(0, 200000) - 100000, -$urandom_range(0, 3000000),
                $urandom_range(0, 200000) - 100000, $urandom_range(0, 65536));
    end else if (mode < 8) begin
      // already overlapping
      send_pair(ox + $urandom_range(0, 2000) - 1000, oy + $urandom_range(0, 2000) - 1000,
                oz + $urandom_range(0, 2000) - 1000, rs, ox, oy, oz, ro,
                $urandom, $urandom, $urandom, $urandom_range(0, 131071));
    end else begin
      send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 131071));
    end
  endtask

  task automatic write_gravity(logic [30:0] g);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    grav <= g;
    grav_we <= 1'b1;
    @(negedge clk);
    grav_we <= 1'b0;
  endtask

  // result side
  initial begin
    int gap;
    pop = 1'b0;
    pop_steady = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 40) == 0) pop_steady = !pop_steady;
      gap = pop_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [30:0] g;
    rst_n = 1'b0;
    push = 1'b0; grav_we = 1'b0; grav = '0; push_steady = 1'b0;
    {self_x, self_y, self_z, other_x, other_y, other_z} = '0;
    {vel_x, vel_y, vel_z, self_r, other_r, dt} = '0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: touching, free, contact, extremes
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(0, 32'h20000, 0, 31'h10000, 0, 0, 0, 31'h10000, 32'h10000, 0, 32'h10000,
              17'h10000);
    send_pair(0, 32'h30000, 0, 31'h10000, 0, 0, 0, 31'h10000, 0, 0, 0, 17'h10000);
    send_pair(0, 32'h28000, 0, 31'h10000, 0, 0, 0, 31'h10000, 0, 32'hfffc0000, 0,
              17'h10000);
    // horizontal offset wider than the sum of radii before the move, none after it
    send_pair(32'h30000, 32'h8000, 0, 31'h8000, 0, 0, 0, 31'h8000, 32'hfffd0000,
              32'hfff00000, 0, 17'h10000);
    // same height: both roots have equal magnitude
    send_pair(32'h30000, 0, 0, 31'h10000, 0, 0, 0, 31'h10000, 32'hfffe0000, 0, 0,
              17'h10000);
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 32'h80000000,
              32'h80000000, 32'h80000000, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 17'h1ffff);
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000, 32'h80000000,
              32'h80000000, 0, 32'h80000000, 32'h80000000, 32'h80000000, 17'h1ffff);
    send_pair(32'h80000000, 32'h7fffffff, 0, 1, 32'h7fffffff, 32'h80000000, 0, 1,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 17'h10000);
    send_pair(0, 32'h7fff0000, 0, 31'h1000, 0, 0, 0, 31'h1000, 0, 32'h7fffffff, 0, 0);
    send_pair(0, 32'h80000000, 0, 31'h1000, 0, 32'h7fffffff, 0, 31'h1000, 0,
              32'h80000000, 0, 17'h1ffff);
    send_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 0, 0, 0, 0,
              32'hffffffff, 32'hffffffff, 32'hffffffff, 17'h00001);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: g = 31'd0;
        1: g = 31'h7fffffff;
        2: g = GravityReset;
        default: g = $urandom;
      endcase
      write_gravity(g);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 30) == 0) push_steady = !push_steady;
        random_pair();
      end
    end
    push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
